/* rtl/core/gdcd_pkg.sv */
`default_nettype none

package gdcd_pkg;

  // arithmetic widths for the speed scaling path
  localparam int unsigned SpeedW  = 8;
  localparam int unsigned DiffW   = SpeedW + 2;  // signed difference of two speeds
  localparam int unsigned ProdW   = DiffW + SpeedW;
  localparam int unsigned WheelW  = 9;

  // configuration register indexes
  localparam logic [2:0] RegBaseSpeed     = 3'd0;
  localparam logic [2:0] RegMinSpeed      = 3'd1;
  localparam logic [2:0] RegMaxSpeed      = 3'd2;
  localparam logic [2:0] RegLiftUpSpeed   = 3'd3;
  localparam logic [2:0] RegLiftDownSpeed = 3'd4;
  localparam logic [2:0] RegResumeDb      = 3'd5;

  localparam logic [7:0] BaseSpeedRst     = 8'd128;
  localparam logic [7:0] MinSpeedRst      = 8'd0;
  localparam logic [7:0] MaxSpeedRst      = 8'd255;
  localparam logic [7:0] LiftUpSpeedRst   = 8'd128;
  localparam logic [7:0] LiftDownSpeedRst = 8'd128;
  localparam logic [6:0] ResumeDbRst      = 7'd20;

  // item kinds
  localparam logic OpReport  = 1'b0;
  localparam logic OpConnect = 1'b1;

  // standby codes
  localparam logic [1:0] StandbyNone  = 2'd0;
  localparam logic [1:0] StandbyEnter = 2'd1;
  localparam logic [1:0] StandbyLeave = 2'd2;

  // lift codes
  localparam logic [1:0] LiftNone = 2'd0;
  localparam logic [1:0] LiftStop = 2'd1;
  localparam logic [1:0] LiftUp   = 2'd2;
  localparam logic [1:0] LiftDown = 2'd3;

  // drive directions
  localparam logic [3:0] DirStop      = 4'd0;
  localparam logic [3:0] DirRight2    = 4'd1;
  localparam logic [3:0] DirLeft2     = 4'd2;
  localparam logic [3:0] DirFwdLeft   = 4'd3;
  localparam logic [3:0] DirFwdRight  = 4'd4;
  localparam logic [3:0] DirTurnLeft  = 4'd5;
  localparam logic [3:0] DirTurnRight = 4'd6;
  localparam logic [3:0] DirBackLeft  = 4'd7;
  localparam logic [3:0] DirBackRight = 4'd8;
  localparam logic [3:0] DirBack      = 4'd9;
  localparam logic [3:0] DirFwd       = 4'd10;
  localparam logic [3:0] DirSpinRight = 4'd11;
  localparam logic [3:0] DirSpinLeft  = 4'd12;

  // stick thresholds
  localparam logic signed [7:0] StickWide   = 8'sd63;
  localparam logic signed [7:0] StickNarrow = 8'sd60;

  // speed cuts per direction group
  localparam logic [5:0] CutSide = 6'd40;
  localparam logic [5:0] CutTurn = 6'd25;
  localparam logic [5:0] CutSpin = 6'd30;

endpackage

`default_nettype wire

/* rtl/core/gdcd_scale_unit.sv */
`default_nettype none

// Shared scaling unit: quot = trunc(diff * factor / 255).
// The first register holds the product, the second the signed quotient.
module gdcd_scale_unit (
  input  wire logic                                  clk_i,
  input  wire logic signed [gdcd_pkg::DiffW-1:0]     diff_i,
  input  wire logic        [gdcd_pkg::SpeedW-1:0]    factor_i,
  output logic signed      [gdcd_pkg::DiffW-1:0]     quot_o
);

  logic signed [gdcd_pkg::ProdW-1:0] prod_q;
  logic signed [gdcd_pkg::ProdW-1:0] prod_d;
  logic        [gdcd_pkg::ProdW-2:0] mag;
  logic        [gdcd_pkg::ProdW-2:0] sum;
  logic        [gdcd_pkg::SpeedW:0]  qmag;
  logic signed [gdcd_pkg::DiffW-1:0] quot_d;
  logic signed [gdcd_pkg::DiffW-1:0] quot_q;

  always_comb begin
    prod_d = $signed({{(gdcd_pkg::ProdW-gdcd_pkg::DiffW){diff_i[gdcd_pkg::DiffW-1]}}, diff_i}) *
             $signed({{(gdcd_pkg::ProdW-gdcd_pkg::SpeedW){1'b0}}, factor_i});
  end

  // |p| / 255 for |p| < 65535 via (x + (x >> 8) + 1) >> 8, then restore sign
  always_comb begin
    mag    = prod_q[gdcd_pkg::ProdW-1] ? (gdcd_pkg::ProdW-1)'(-prod_q)
                                       : prod_q[gdcd_pkg::ProdW-2:0];
    sum    = mag + (mag >> 8) + (gdcd_pkg::ProdW-1)'(1);
    qmag   = sum[gdcd_pkg::ProdW-2:8];
    quot_d = prod_q[gdcd_pkg::ProdW-1] ? -$signed({1'b0, qmag})
                                       : $signed({1'b0, qmag});
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    quot_q <= quot_d;
  end

  assign quot_o = quot_q;

endmodule

`default_nettype wire

/* rtl/core/gamepad_drive_command_decoder_unit.sv */
`default_nettype none

// Gamepad drive command decoder. Each input word is a gamepad report or, with
// tuser set, a controller-connect event; each yields exactly one output word.
// A word is captured on acceptance and then steps through the states in order:
// one shared multiply/divide-by-255 unit is used twice in turn (R2 raise, then
// L2 cut), each time with a multiply, a divide and an accumulate state,
// followed by a finish state for clamp, direction and the emergency-stop latch
// that writes the output register, then a return to idle. The input is ready
// only in idle; a finished word waits in the output register without
// blocking the next input, and a word still held there stalls the finish
// cycle of the next one.
// Configuration writes take effect at once and should only be made when idle.
module gamepad_drive_command_decoder_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [7:0]  cfg_wdata_i,
  // input words
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // lsb up: stick_lx, stick_ly, stick_rx, stick_ry, trigger_r2, trigger_l2,
  //         shoulder_r1, shoulder_l1, held_buttons[69:64], zero pad
  input  wire logic [71:0] s_axis_tdata_i,
  // operation
  input  wire logic        s_axis_tuser_i,
  // output words
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // lsb up: estop_active, standby_action[2:1], drive_valid, direction[7:4],
  //         wheel_speed[16:8], lift_action[18:17], lift_speed[26:19], zero pad
  output logic [31:0]      m_axis_tdata_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_UP_MUL, ST_UP_DIV, ST_UP_ACC, ST_DN_MUL, ST_DN_DIV, ST_DN_ACC, ST_FIN
  } state_e;

  // configuration registers
  logic [7:0] base_q, min_q, max_q, lift_up_q, lift_dn_q;
  logic [6:0] db_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= gdcd_pkg::BaseSpeedRst;
      min_q     <= gdcd_pkg::MinSpeedRst;
      max_q     <= gdcd_pkg::MaxSpeedRst;
      lift_up_q <= gdcd_pkg::LiftUpSpeedRst;
      lift_dn_q <= gdcd_pkg::LiftDownSpeedRst;
      db_q      <= gdcd_pkg::ResumeDbRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        gdcd_pkg::RegBaseSpeed:     base_q    <= cfg_wdata_i;
        gdcd_pkg::RegMinSpeed:      min_q     <= cfg_wdata_i;
        gdcd_pkg::RegMaxSpeed:      max_q     <= cfg_wdata_i;
        gdcd_pkg::RegLiftUpSpeed:   lift_up_q <= cfg_wdata_i;
        gdcd_pkg::RegLiftDownSpeed: lift_dn_q <= cfg_wdata_i;
        gdcd_pkg::RegResumeDb:      db_q      <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  function automatic logic [7:0] mag8(input logic signed [7:0] v);
    mag8 = v[7] ? 8'(-v) : v;
  endfunction

  function automatic logic [3:0] pick_dir(input logic signed [7:0] lx,
                                          input logic signed [7:0] ly,
                                          input logic signed [7:0] rx,
                                          input logic signed [7:0] ry,
                                          input logic [5:0]        btn);
    logic signed [7:0] w;
    logic signed [7:0] n;
    logic ry_mid, lx_mid, ly_mid;
    w = gdcd_pkg::StickWide;
    n = gdcd_pkg::StickNarrow;
    ry_mid = (ry > -w) && (ry < w);
    lx_mid = (lx > -w) && (lx < w);
    ly_mid = (ly > -w) && (ly < w);
    if      (ry_mid && rx < -n)   pick_dir = gdcd_pkg::DirRight2;
    else if (ry_mid && rx > n)    pick_dir = gdcd_pkg::DirLeft2;
    else if (lx < -w && ly < -w)  pick_dir = gdcd_pkg::DirFwdLeft;
    else if (lx > w && ly < -w)   pick_dir = gdcd_pkg::DirFwdRight;
    else if (rx < -w && ry < -w)  pick_dir = gdcd_pkg::DirTurnLeft;
    else if (rx > w && ry < -w)   pick_dir = gdcd_pkg::DirTurnRight;
    else if (ly > w && lx < -w)   pick_dir = gdcd_pkg::DirBackLeft;
    else if (ly > w && lx > w)    pick_dir = gdcd_pkg::DirBackRight;
    else if (lx_mid && ly > n)    pick_dir = gdcd_pkg::DirBack;
    else if (lx_mid && ly < -n)   pick_dir = gdcd_pkg::DirFwd;
    else if (ly_mid && lx < -n)   pick_dir = gdcd_pkg::DirSpinRight;
    else if (ly_mid && lx > n)    pick_dir = gdcd_pkg::DirSpinLeft;
    else if (btn[2])              pick_dir = gdcd_pkg::DirFwd;
    else if (btn[3])              pick_dir = gdcd_pkg::DirBack;
    else if (btn[4])              pick_dir = gdcd_pkg::DirSpinLeft;
    else if (btn[5])              pick_dir = gdcd_pkg::DirSpinRight;
    else                          pick_dir = gdcd_pkg::DirStop;
  endfunction

  state_e state_q;
  logic   estop_q;
  logic   out_valid_q;

  // captured input word
  logic              op_q;
  logic signed [7:0] lx_q, ly_q, rx_q, ry_q;
  logic [7:0]        r2_q, l2_q, r1_q, l1_q;
  logic [5:0]        btn_q;

  // running speed
  logic signed [gdcd_pkg::DiffW-1:0] spd_q;

  // output word fields
  logic                             o_estop_q;
  logic [1:0]                       o_standby_q;
  logic                             o_dvalid_q;
  logic [3:0]                       o_dir_q;
  logic signed [gdcd_pkg::WheelW-1:0] o_wspd_q;
  logic [1:0]                       o_lact_q;
  logic [7:0]                       o_lspd_q;

  logic signed [gdcd_pkg::DiffW-1:0] unit_diff;
  logic        [7:0]                 unit_factor;
  logic signed [gdcd_pkg::DiffW-1:0] unit_quot;

  gdcd_scale_unit u_scale (
    .clk_i    (clk_i),
    .diff_i   (unit_diff),
    .factor_i (unit_factor),
    .quot_o   (unit_quot)
  );

  logic signed [gdcd_pkg::DiffW-1:0] mn_s, mx_s;
  assign mn_s = $signed({2'b00, min_q});
  assign mx_s = $signed({2'b00, max_q});

  always_comb begin
    if (state_q == ST_DN_MUL) begin
      unit_diff   = spd_q - mn_s;
      unit_factor = l2_q;
    end else begin
      unit_diff   = mx_s - spd_q;
      unit_factor = r2_q;
    end
  end

  // final-cycle decode
  logic                             resume;
  logic signed [gdcd_pkg::DiffW-1:0] clamped;
  logic [3:0]                       dir;
  logic [5:0]                       cut;
  logic signed [gdcd_pkg::DiffW-1:0] wheel;
  logic                             fin_estop;
  logic [1:0]                       fin_standby;
  logic                             fin_dvalid;
  logic [3:0]                       fin_dir;
  logic signed [gdcd_pkg::WheelW-1:0] fin_wspd;
  logic [1:0]                       fin_lact;
  logic [7:0]                       fin_lspd;
  logic                             out_free;

  always_comb begin
    resume = (mag8(lx_q) > {1'b0, db_q}) || (mag8(ly_q) > {1'b0, db_q}) ||
             (mag8(rx_q) > {1'b0, db_q}) || (mag8(ry_q) > {1'b0, db_q});
    // min is tested first, so min above max yields max unless below min
    if (spd_q < mn_s)      clamped = mn_s;
    else if (spd_q > mx_s) clamped = mx_s;
    else                   clamped = spd_q;
    dir = pick_dir(lx_q, ly_q, rx_q, ry_q, btn_q);
    case (dir)
      gdcd_pkg::DirRight2, gdcd_pkg::DirLeft2:        cut = gdcd_pkg::CutSide;
      gdcd_pkg::DirTurnLeft, gdcd_pkg::DirTurnRight:  cut = gdcd_pkg::CutTurn;
      gdcd_pkg::DirSpinRight, gdcd_pkg::DirSpinLeft:  cut = gdcd_pkg::CutSpin;
      default:                                        cut = 6'd0;
    endcase
    wheel = clamped - $signed({4'b0000, cut});

    fin_estop   = estop_q;
    fin_standby = gdcd_pkg::StandbyNone;
    fin_dvalid  = 1'b0;
    fin_dir     = gdcd_pkg::DirStop;
    fin_wspd    = '0;
    fin_lact    = gdcd_pkg::LiftNone;
    fin_lspd    = '0;
    if (op_q == gdcd_pkg::OpConnect) begin
      fin_estop   = 1'b0;
      fin_standby = gdcd_pkg::StandbyLeave;
    end else if (btn_q[1:0] == 2'b11) begin
      if (!estop_q) begin
        fin_estop   = 1'b1;
        fin_standby = gdcd_pkg::StandbyEnter;
        fin_lact    = gdcd_pkg::LiftStop;
      end
    end else if (estop_q) begin
      if (resume) begin
        fin_estop   = 1'b0;
        fin_standby = gdcd_pkg::StandbyLeave;
      end
    end else begin
      fin_dvalid = 1'b1;
      fin_dir    = dir;
      fin_wspd   = wheel[gdcd_pkg::WheelW-1:0];
      if (r1_q != 8'd0) begin
        fin_lact = gdcd_pkg::LiftUp;
        fin_lspd = lift_up_q;
      end else if (l1_q != 8'd0) begin
        fin_lact = gdcd_pkg::LiftDown;
        fin_lspd = lift_dn_q;
      end else begin
        fin_lact = gdcd_pkg::LiftStop;
      end
    end
  end

  assign out_free = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      estop_q     <= 1'b0;
      out_valid_q <= 1'b0;
      op_q        <= 1'b0;
      lx_q        <= '0;
      ly_q        <= '0;
      rx_q        <= '0;
      ry_q        <= '0;
      r2_q        <= '0;
      l2_q        <= '0;
      r1_q        <= '0;
      l1_q        <= '0;
      btn_q       <= '0;
      spd_q       <= '0;
      o_estop_q   <= 1'b0;
      o_standby_q <= gdcd_pkg::StandbyNone;
      o_dvalid_q  <= 1'b0;
      o_dir_q     <= gdcd_pkg::DirStop;
      o_wspd_q    <= '0;
      o_lact_q    <= gdcd_pkg::LiftNone;
      o_lspd_q    <= '0;
    end else begin
      // the finish cycle refills the output register itself
      if (out_valid_q && m_axis_tready_i && state_q != ST_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            op_q    <= s_axis_tuser_i;
            lx_q    <= s_axis_tdata_i[7:0];
            ly_q    <= s_axis_tdata_i[15:8];
            rx_q    <= s_axis_tdata_i[23:16];
            ry_q    <= s_axis_tdata_i[31:24];
            r2_q    <= s_axis_tdata_i[39:32];
            l2_q    <= s_axis_tdata_i[47:40];
            r1_q    <= s_axis_tdata_i[55:48];
            l1_q    <= s_axis_tdata_i[63:56];
            btn_q   <= s_axis_tdata_i[69:64];
            spd_q   <= $signed({2'b00, base_q});
            state_q <= ST_UP_MUL;
          end
        end
        ST_UP_MUL: state_q <= ST_UP_DIV;
        ST_UP_DIV: state_q <= ST_UP_ACC;
        ST_UP_ACC: begin
          spd_q   <= spd_q + unit_quot;
          state_q <= ST_DN_MUL;
        end
        ST_DN_MUL: state_q <= ST_DN_DIV;
        ST_DN_DIV: state_q <= ST_DN_ACC;
        ST_DN_ACC: begin
          spd_q   <= spd_q - unit_quot;
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            estop_q     <= fin_estop;
            out_valid_q <= 1'b1;
            o_estop_q   <= fin_estop;
            o_standby_q <= fin_standby;
            o_dvalid_q  <= fin_dvalid;
            o_dir_q     <= fin_dir;
            o_wspd_q    <= fin_wspd;
            o_lact_q    <= fin_lact;
            o_lspd_q    <= fin_lspd;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b00000, o_lspd_q, o_lact_q, o_wspd_q, o_dir_q,
                            o_dvalid_q, o_standby_q, o_estop_q};

  // latch moves only when a word is finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (estop_q != $past(estop_q)) |-> ($past(state_q) == ST_FIN))
    else $error("estop latch changed outside finish cycle");

  // drive is never issued while stopped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && o_dvalid_q) |-> !o_estop_q)
    else $error("drive issued with estop active");

  // lift speed only with up or down
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && o_lspd_q != 8'd0) |->
      (o_lact_q == gdcd_pkg::LiftUp || o_lact_q == gdcd_pkg::LiftDown))
    else $error("lift speed without lift move");

  // wheel speed stays in its range after the cut
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && o_dvalid_q) |-> (o_wspd_q >= -9'sd40))
    else $error("wheel speed out of range");

endmodule

`default_nettype wire

/* bench/gamepad_drive_command_decoder_unit_tb.sv */
`timescale 1ns / 100ps

module gamepad_drive_command_decoder_unit_tb;

  // held_buttons bit positions
  localparam int BtnL3    = 0;
  localparam int BtnR3    = 1;
  localparam int BtnUp    = 2;
  localparam int BtnDown  = 3;
  localparam int BtnRight = 4;
  localparam int BtnLeft  = 5;

  localparam int MaxPrinted = 40;

  typedef struct {
    logic              op;
    logic signed [7:0] lx, ly, rx, ry;
    logic [7:0]        r2, l2, r1, l1;
    logic [5:0]        btn;
  } pad_word_t;

  typedef struct {
    logic              estop;
    logic [1:0]        standby;
    logic              drive;
    logic [3:0]        dir;
    logic signed [8:0] wheel;
    logic [1:0]        lift;
    logic [7:0]        lift_spd;
  } drive_cmd_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_addr  = '0;
  logic [7:0]  cfg_wdata = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata   = '0;
  logic        s_tuser   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;

  // shadow copy of the decoder's registers and stop latch
  int cfg_base     = gdcd_pkg::BaseSpeedRst;
  int cfg_min      = gdcd_pkg::MinSpeedRst;
  int cfg_max      = gdcd_pkg::MaxSpeedRst;
  int cfg_lift_up  = gdcd_pkg::LiftUpSpeedRst;
  int cfg_lift_dn  = gdcd_pkg::LiftDownSpeedRst;
  int cfg_deadband = gdcd_pkg::ResumeDbRst;
  bit estop_model  = 1'b0;

  drive_cmd_t cmd_expected_q[$];

  int err_cnt     = 0;
  int n_sent      = 0;
  int n_checked   = 0;
  int n_connects  = 0;
  int n_latches   = 0;
  int n_resumes   = 0;
  int n_drives    = 0;
  int n_settings  = 0;
  logic [12:0] dir_seen = '0;

  // sender burst state
  int burst_left = 0;

  // receiver stall state
  int hold_request = 0;
  int hold_cnt     = 0;
  int rx_mode      = 0;
  int mode_left    = 0;
  int rx_tick      = 0;

  gamepad_drive_command_decoder_unit i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // prediction

  function automatic int stick_mag(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [3:0] pick_heading(input int lx, input int ly, input int rx,
                                              input int ry, input logic [5:0] btn);
    int wd;
    int nr;
    wd = gdcd_pkg::StickWide;
    nr = gdcd_pkg::StickNarrow;
    if (ry > -wd && ry < wd && rx < -nr) return gdcd_pkg::DirRight2;
    if (ry > -wd && ry < wd && rx > nr) return gdcd_pkg::DirLeft2;
    if (lx < -wd && ly < -wd) return gdcd_pkg::DirFwdLeft;
    if (lx > wd && ly < -wd) return gdcd_pkg::DirFwdRight;
    if (rx < -wd && ry < -wd) return gdcd_pkg::DirTurnLeft;
    if (rx > wd && ry < -wd) return gdcd_pkg::DirTurnRight;
    if (ly > wd && lx < -wd) return gdcd_pkg::DirBackLeft;
    if (ly > wd && lx > wd) return gdcd_pkg::DirBackRight;
    if (lx > -wd && lx < wd && ly > nr) return gdcd_pkg::DirBack;
    if (lx > -wd && lx < wd && ly < -nr) return gdcd_pkg::DirFwd;
    if (ly > -wd && ly < wd && lx < -nr) return gdcd_pkg::DirSpinRight;
    if (ly > -wd && ly < wd && lx > nr) return gdcd_pkg::DirSpinLeft;
    // d-pad only when the sticks say nothing
    if (btn[BtnUp]) return gdcd_pkg::DirFwd;
    if (btn[BtnDown]) return gdcd_pkg::DirBack;
    if (btn[BtnRight]) return gdcd_pkg::DirSpinLeft;
    if (btn[BtnLeft]) return gdcd_pkg::DirSpinRight;
    return gdcd_pkg::DirStop;
  endfunction

  // updates the shadow stop latch
  function automatic drive_cmd_t decode_report(input pad_word_t w);
    drive_cmd_t c;
    int lx, ly, rx, ry, s, r2, l2;
    c  = '{default: '0};
    lx = w.lx;
    ly = w.ly;
    rx = w.rx;
    ry = w.ry;
    r2 = w.r2;
    l2 = w.l2;
    if (w.op == gdcd_pkg::OpConnect) begin
      estop_model = 1'b0;
      c.standby   = gdcd_pkg::StandbyLeave;
    end else if (w.btn[BtnL3] && w.btn[BtnR3]) begin
      if (!estop_model) begin
        estop_model = 1'b1;
        c.standby   = gdcd_pkg::StandbyEnter;
        c.lift      = gdcd_pkg::LiftStop;
      end
    end else if (estop_model) begin
      if (stick_mag(lx) > cfg_deadband || stick_mag(ly) > cfg_deadband ||
          stick_mag(rx) > cfg_deadband || stick_mag(ry) > cfg_deadband) begin
        estop_model = 1'b0;
        c.standby   = gdcd_pkg::StandbyLeave;
      end
    end else begin
      s = cfg_base;
      if (r2 > 0) s = s + (cfg_max - s) * r2 / 255;
      if (l2 > 0) s = s - (s - cfg_min) * l2 / 255;
      // min is tested first, so min above max yields max unless below min
      if (s < cfg_min) s = cfg_min;
      else if (s > cfg_max) s = cfg_max;
      c.dir = pick_heading(lx, ly, rx, ry, w.btn);
      case (c.dir)
        gdcd_pkg::DirRight2, gdcd_pkg::DirLeft2:       s = s - int'(gdcd_pkg::CutSide);
        gdcd_pkg::DirTurnLeft, gdcd_pkg::DirTurnRight: s = s - int'(gdcd_pkg::CutTurn);
        gdcd_pkg::DirSpinRight, gdcd_pkg::DirSpinLeft: s = s - int'(gdcd_pkg::CutSpin);
        default: ;
      endcase
      c.drive = 1'b1;
      c.wheel = s[8:0];
      if (w.r1 != 0) begin
        c.lift     = gdcd_pkg::LiftUp;
        c.lift_spd = cfg_lift_up[7:0];
      end else if (w.l1 != 0) begin
        c.lift     = gdcd_pkg::LiftDown;
        c.lift_spd = cfg_lift_dn[7:0];
      end else begin
        c.lift = gdcd_pkg::LiftStop;
      end
    end
    c.estop = estop_model;
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // word builders

  function automatic pad_word_t make_report(input int lx, input int ly, input int rx,
                                            input int ry, input int r2, input int l2,
                                            input int r1, input int l1, input int btn);
    pad_word_t w;
    w.op  = gdcd_pkg::OpReport;
    w.lx  = lx[7:0];
    w.ly  = ly[7:0];
    w.rx  = rx[7:0];
    w.ry  = ry[7:0];
    w.r2  = r2[7:0];
    w.l2  = l2[7:0];
    w.r1  = r1[7:0];
    w.l1  = l1[7:0];
    w.btn = btn[5:0];
    return w;
  endfunction

  function automatic logic signed [7:0] rand_stick();
    int v;
    case ($urandom_range(0, 5))
      0: v = 0;
      1, 2: v = int'($urandom_range(0, 255)) - 128;
      // around the 60 and 63 thresholds
      3: v = $urandom_range(0, 1) ? int'($urandom_range(58, 65)) : -int'($urandom_range(58, 65));
      4: v = $urandom_range(0, 1) ? 127 : -128;
      default: v = int'($urandom_range(0, 60)) - 30;
    endcase
    return v[7:0];
  endfunction

  function automatic logic [7:0] rand_level();
    case ($urandom_range(0, 6))
      0, 1, 2: return 8'd0;
      3: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // report that never holds both stick clicks
  function automatic pad_word_t rand_report();
    pad_word_t w;
    w.op  = gdcd_pkg::OpReport;
    w.lx  = rand_stick();
    w.ly  = rand_stick();
    w.rx  = rand_stick();
    w.ry  = rand_stick();
    w.r2  = rand_level();
    w.l2  = rand_level();
    w.r1  = $urandom_range(0, 1) ? 8'd0 : rand_level();
    w.l1  = $urandom_range(0, 1) ? 8'd0 : rand_level();
    w.btn = 6'($urandom_range(0, 63));
    if (w.btn[BtnL3] && w.btn[BtnR3]) begin
      if ($urandom_range(0, 1)) w.btn[BtnL3] = 1'b0;
      else w.btn[BtnR3] = 1'b0;
    end
    return w;
  endfunction

  function automatic pad_word_t stop_word();
    pad_word_t w;
    w = rand_report();
    w.btn[BtnL3] = 1'b1;
    w.btn[BtnR3] = 1'b1;
    return w;
  endfunction

  // latched report with every stick inside the resume deadband
  function automatic pad_word_t quiet_word();
    pad_word_t w;
    int v[4];
    w = rand_report();
    foreach (v[i]) begin
      v[i] = int'($urandom_range(0, 2 * cfg_deadband)) - cfg_deadband;
      if ($urandom_range(0, 3) == 0) v[i] = $urandom_range(0, 1) ? cfg_deadband : -cfg_deadband;
    end
    w.lx = v[0][7:0];
    w.ly = v[1][7:0];
    w.rx = v[2][7:0];
    w.ry = v[3][7:0];
    return w;
  endfunction

  // one stick just or well past the deadband
  function automatic pad_word_t wake_word();
    pad_word_t w;
    int m;
    w = quiet_word();
    m = $urandom_range(0, 1) ? cfg_deadband + 1 : int'($urandom_range(cfg_deadband + 1, 128));
    if (m == 128 || $urandom_range(0, 1)) m = -m;
    case ($urandom_range(0, 3))
      0: w.lx = m[7:0];
      1: w.ly = m[7:0];
      2: w.rx = m[7:0];
      default: w.ry = m[7:0];
    endcase
    return w;
  endfunction

  function automatic pad_word_t noise_word();
    pad_word_t w;
    w.op  = 1'($urandom_range(0, 1));
    w.lx  = 8'($urandom);
    w.ly  = 8'($urandom);
    w.rx  = 8'($urandom);
    w.ry  = 8'($urandom);
    w.r2  = 8'($urandom);
    w.l2  = 8'($urandom);
    w.r1  = 8'($urandom);
    w.l1  = 8'($urandom);
    w.btn = 6'($urandom);
    return w;
  endfunction

  function automatic pad_word_t connect_word();
    pad_word_t w;
    w    = noise_word();
    w.op = gdcd_pkg::OpConnect;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // sender and register access

  task automatic send_word(input pad_word_t w);
    int gap;
    drive_cmd_t c;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= w.op;
    s_tdata  <= {2'b00, w.btn, w.l1, w.r1, w.l2, w.r2, w.ry, w.rx, w.ly, w.lx};
    do @(posedge clk); while (!s_tready);
    burst_left--;
    c = decode_report(w);
    cmd_expected_q.push_back(c);
    n_sent++;
    if (w.op == gdcd_pkg::OpConnect) n_connects++;
    if (c.standby == gdcd_pkg::StandbyEnter) n_latches++;
    if (c.standby == gdcd_pkg::StandbyLeave && w.op == gdcd_pkg::OpReport) n_resumes++;
    if (c.drive) begin
      n_drives++;
      dir_seen[c.dir] = 1'b1;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (cmd_expected_q.size() != 0) @(posedge clk);
    // every word yields a result, so the decoder is idle by now; a little margin
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val[7:0];
    case (idx)
      gdcd_pkg::RegBaseSpeed:     cfg_base     = val & 8'hFF;
      gdcd_pkg::RegMinSpeed:      cfg_min      = val & 8'hFF;
      gdcd_pkg::RegMaxSpeed:      cfg_max      = val & 8'hFF;
      gdcd_pkg::RegLiftUpSpeed:   cfg_lift_up  = val & 8'hFF;
      gdcd_pkg::RegLiftDownSpeed: cfg_lift_dn  = val & 8'hFF;
      gdcd_pkg::RegResumeDb:      cfg_deadband = val & 8'h7F;
      default: ;
    endcase
  endtask

  task automatic apply_config(input int base, input int mn, input int mx, input int up,
                              input int dn, input int db);
    wait_drained();
    write_reg(gdcd_pkg::RegBaseSpeed, base);
    write_reg(gdcd_pkg::RegMinSpeed, mn);
    write_reg(gdcd_pkg::RegMaxSpeed, mx);
    write_reg(gdcd_pkg::RegLiftUpSpeed, up);
    write_reg(gdcd_pkg::RegLiftDownSpeed, dn);
    write_reg(gdcd_pkg::RegResumeDb, db);
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic int rand_speed_reg();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // receiver and checker

  always @(negedge clk) begin
    rx_tick++;
    if (hold_request != 0) begin
      hold_cnt     = hold_request;
      hold_request = 0;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 128);
      end
      mode_left--;
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= (rx_tick % 3 != 0);
      endcase
    end
  end

  task automatic report_error(input string msg);
    if (err_cnt < MaxPrinted) $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] got,
                             input logic signed [31:0] want);
    if (got !== want)
      report_error($sformatf("word %0d: %s is %0d, expected %0d", n_checked, name, got, want));
  endtask

  always @(posedge clk) begin
    drive_cmd_t want;
    if (rst_n && m_tvalid && m_tready) begin
      if (cmd_expected_q.size() == 0) begin
        report_error($sformatf("output word 0x%08h with nothing outstanding", m_tdata));
      end else begin
        want = cmd_expected_q.pop_front();
        check_field("estop_active", m_tdata[0], want.estop);
        check_field("standby_action", m_tdata[2:1], want.standby);
        check_field("drive_valid", m_tdata[3], want.drive);
        check_field("direction", m_tdata[7:4], want.dir);
        check_field("wheel_speed", $signed(m_tdata[16:8]), want.wheel);
        check_field("lift_action", m_tdata[18:17], want.lift);
        check_field("lift_speed", m_tdata[26:19], want.lift_spd);
        check_field("pad bits", m_tdata[31:27], 0);
        n_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests

  // reset register values; at least one word per direction, trigger extremes and the
  // stop-latch corner cases
  task automatic test_directed();
    pad_word_t w;
    send_word(make_report(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_report(0, 0, -128, 0, 0, 0, 0, 0, 0));
    send_word(make_report(0, 0, 127, 62, 0, 0, 0, 0, 0));
    send_word(make_report(-128, -128, 0, 0, 255, 0, 0, 0, 0));
    send_word(make_report(127, -128, 0, 0, 0, 255, 0, 0, 0));
    send_word(make_report(0, 0, -128, -128, 255, 255, 0, 255, 0));
    send_word(make_report(0, 0, 127, -64, 1, 1, 255, 0, 0));
    send_word(make_report(-128, 127, 0, 0, 0, 0, 0, 1, 0));
    send_word(make_report(127, 127, 0, 0, 0, 0, 1, 1, 0));
    send_word(make_report(62, 61, -60, 0, 0, 0, 0, 0, 0));
    send_word(make_report(-62, -61, 60, 0, 0, 0, 0, 0, 0));
    send_word(make_report(-61, 62, 0, -62, 0, 0, 0, 0, 0));
    send_word(make_report(63, -62, 0, 0, 0, 0, 0, 0, 0));
    // d-pad priority: up over all, then down, right, left
    send_word(make_report(0, 0, 0, 0, 0, 0, 0, 0, 6'h3C));
    send_word(make_report(0, 0, 0, 0, 0, 0, 0, 0, 6'h38));
    send_word(make_report(0, 0, 0, 0, 0, 0, 0, 0, 6'h31));
    send_word(make_report(0, 0, 0, 0, 0, 0, 0, 0, 6'h22));
    // latch, repeat while latched, stay inside deadband, then resume
    send_word(make_report(0, 0, 0, 0, 0, 0, 255, 0, 6'h03));
    send_word(make_report(127, 127, 127, 127, 0, 0, 255, 0, 6'h3F));
    send_word(make_report(20, -20, 20, -20, 0, 0, 255, 255, 6'h3D));
    send_word(make_report(0, 0, 0, -21, 0, 0, 0, 0, 0));
    send_word(make_report(0, 0, 0, 0, 0, 0, 0, 0, 6'h03));
    // connect while latched and while clear, junk in the other fields
    w = noise_word();
    w.op = gdcd_pkg::OpConnect;
    w.btn = 6'h3F;
    send_word(w);
    send_word(connect_word());
  endtask

  task automatic test_register_settings();
    int settings[6][6] = '{
      '{0, 0, 0, 0, 255, 0},
      '{255, 255, 255, 255, 0, 127},
      '{200, 50, 100, 1, 254, 1},       // base above max
      '{10, 100, 50, 170, 85, 64},      // min above max, base below min
      '{128, 30, 220, 77, 99, 63},
      '{255, 0, 255, 128, 128, 126}
    };
    foreach (settings[i]) begin
      apply_config(settings[i][0], settings[i][1], settings[i][2], settings[i][3],
                   settings[i][4], settings[i][5]);
      random_traffic(50);
    end
  endtask

  // receiver holds off long enough for the decoder to fill and stall its input
  task automatic test_output_stall();
    hold_request = 400;
    repeat (40) send_word(rand_report());
  endtask

  task automatic test_random_mix();
    repeat (4) begin
      apply_config(rand_speed_reg(), rand_speed_reg(), rand_speed_reg(),
                   rand_speed_reg(), rand_speed_reg(), $urandom_range(0, 127));
      random_traffic(110);
    end
  endtask

  // mostly valid reports and stop/resume sequences, some connects and noise
  task automatic random_traffic(input int count);
    int sent;
    int pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_word(rand_report());
        sent++;
      end else if (pick < 80) begin
        send_word(stop_word());
        sent++;
        repeat ($urandom_range(0, 4)) begin
          if ($urandom_range(0, 5) == 0) send_word(stop_word());
          else send_word(quiet_word());
          sent++;
        end
        if ($urandom_range(0, 3) == 0) send_word(connect_word());
        else send_word(wake_word());
        sent++;
      end else if (pick < 88) begin
        send_word(connect_word());
        sent++;
      end else begin
        send_word(noise_word());
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_register_settings();
    test_output_stall();
    test_random_mix();
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d words: %0d drive commands, %0d stop latches, %0d resumes, %0d connects",
             n_sent, n_drives, n_latches, n_resumes, n_connects);
    $display("%0d register settings, %0d of 13 directions seen, %0d results checked",
             n_settings, $countones(dir_seen), n_checked);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", cmd_expected_q.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
